@@ hdl/cdkf_pkg.sv @@
// Shared types, widths and register codes for the color distance key fade block.
package cdkf_pkg;

    // Field and arithmetic widths.
    localparam int CHAN_W    = 8;
    localparam int DIST_W    = 9;
    localparam int SUMSQ_W   = 18;
    localparam int SQ_W      = 16;
    localparam int RAD_W     = SUMSQ_W + 16;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int NUM_W     = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 9;

    // Default number of fraction bits in the fade factor.
    localparam int FACTOR_FRAC_BITS_DEF = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_BLUE   = 3'd0,
        CFG_KEY_GREEN  = 3'd1,
        CFG_KEY_RED    = 3'd2,
        CFG_KEY_ALPHA  = 3'd3,
        CFG_MATCH_DIST = 3'd4
    } t_cfg_idx;

    // Input pixel.
    typedef struct packed {
        logic [CHAN_W-1:0] pixel_blue;
        logic [CHAN_W-1:0] pixel_green;
        logic [CHAN_W-1:0] pixel_red;
        logic [CHAN_W-1:0] pixel_alpha;
    } t_pix_in;

    // Result pixel.
    typedef struct packed {
        logic [CHAN_W-1:0] result_blue;
        logic [CHAN_W-1:0] result_green;
        logic [CHAN_W-1:0] result_red;
        logic [CHAN_W-1:0] result_alpha;
        logic              matched;
    } t_pix_out;

    // Data that rides alongside the arithmetic pipelines.
    typedef struct packed {
        t_pix_in           pix;
        logic [CHAN_W-1:0] sat_blue;
        logic [CHAN_W-1:0] sat_green;
        logic [CHAN_W-1:0] sat_red;
        logic              matched;
    } t_side;

endpackage

@@ hdl/cdkf_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage.
module cdkf_sqrt_pipe
    import cdkf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    localparam int REM_W = RAD_W + 2;

    logic [REM_W-1:0]  r_rem   [ROOT_W];
    logic [ROOT_W-1:0] r_root  [ROOT_W];
    t_side             r_side  [ROOT_W];
    logic              r_valid [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            localparam int BIT = ROOT_W - 1 - k;
            logic [REM_W-1:0]  s_rem;
            logic [ROOT_W-1:0] s_root;
            t_side             s_side;
            logic              s_valid;
            logic [REM_W-1:0]  s_trial;
            logic [REM_W-1:0]  n_rem;
            logic [ROOT_W-1:0] n_root;

            // Stage inputs come from the port or from the stage before.
            if (k == 0) begin : g_first
                assign s_rem   = REM_W'(i_rad);
                assign s_root  = '0;
                assign s_side  = i_side;
                assign s_valid = i_valid;
            end else begin : g_next
                assign s_rem   = r_rem[k-1];
                assign s_root  = r_root[k-1];
                assign s_side  = r_side[k-1];
                assign s_valid = r_valid[k-1];
            end

            // Setting this root bit adds root*2^(BIT+1) + 2^(2*BIT) to the square.
            always_comb begin
                s_trial = (REM_W'(s_root) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
                if (s_rem >= s_trial) begin
                    n_rem  = s_rem - s_trial;
                    n_root = s_root | (ROOT_W'(1) << BIT);
                end else begin
                    n_rem  = s_rem;
                    n_root = s_root;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= s_valid;
                end
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                    r_side[k] <= s_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

@@ hdl/cdkf_div_pipe.sv @@
// Pipelined restoring divider for the fade factor, one quotient bit per stage.
module cdkf_div_pipe
    import cdkf_pkg::*;
#(
    parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [NUM_W-1:0]            i_dvs,
    input  t_side                       i_side,
    output logic                        o_valid,
    output logic [FACTOR_FRAC_BITS-1:0] o_quot,
    output t_side                       o_side
);

    localparam int QW    = FACTOR_FRAC_BITS;
    localparam int REM_W = NUM_W + 1;

    logic [NUM_W-1:0] r_rem   [QW];
    logic [QW-1:0]    r_quot  [QW];
    t_side            r_side  [QW];
    logic             r_valid [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [NUM_W-1:0] s_rem;
            logic [QW-1:0]    s_quot;
            t_side            s_side;
            logic             s_valid;
            logic [REM_W-1:0] s_dbl;
            logic [NUM_W-1:0] n_rem;
            logic [QW-1:0]    n_quot;

            if (k == 0) begin : g_first
                assign s_rem   = i_num;
                assign s_quot  = '0;
                assign s_side  = i_side;
                assign s_valid = i_valid;
            end else begin : g_next
                assign s_rem   = r_rem[k-1];
                assign s_quot  = r_quot[k-1];
                assign s_side  = r_side[k-1];
                assign s_valid = r_valid[k-1];
            end

            // Remainder stays below the divisor, so its double fits one more bit.
            // A zero divisor gives a zero quotient.
            always_comb begin
                s_dbl = {s_rem, 1'b0};
                if ((i_dvs != '0) && (s_dbl >= REM_W'(i_dvs))) begin
                    n_rem  = NUM_W'(s_dbl - REM_W'(i_dvs));
                    n_quot = {s_quot[QW-2:0], 1'b1};
                end else begin
                    n_rem  = NUM_W'(s_dbl);
                    n_quot = {s_quot[QW-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= s_valid;
                end
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_quot[k] <= n_quot;
                    r_side[k] <= s_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

@@ hdl/color_distance_key_fade.sv @@
// Top level of the color distance key fade pipeline.
//
//  Channel   Signals                                    Moves
//  input     i_in_valid, o_in_ready, i_in_data          one pixel per transfer
//  output    o_out_valid, i_out_ready, o_out_data       one keyed pixel per transfer
//  config    i_cfg_we, i_cfg_idx, i_cfg_data            one register write per cycle
//
// One pixel enters per clock unless the output stalls; the pipeline holds the
// square root stages (one root bit each) and the divider stages
// (one factor bit each) between its registered stages.
// Reset clears all valid bits and loads the key to zero and the distance to one.
// When the output register holds a result that is not taken, the whole pipeline
// holds; nothing is dropped or repeated.
module color_distance_key_fade
    import cdkf_pkg::*;
#(
    parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_pix_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_pix_out             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int QW = FACTOR_FRAC_BITS;

    // Configuration registers.
    logic [CHAN_W-1:0] r_key_b, r_key_g, r_key_r, r_key_a;
    logic [DIST_W-1:0] r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_b <= '0;
            r_key_g <= '0;
            r_key_r <= '0;
            r_key_a <= '0;
            r_dist  <= DIST_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_BLUE:   r_key_b <= i_cfg_data[CHAN_W-1:0];
                CFG_KEY_GREEN:  r_key_g <= i_cfg_data[CHAN_W-1:0];
                CFG_KEY_RED:    r_key_r <= i_cfg_data[CHAN_W-1:0];
                CFG_KEY_ALPHA:  r_key_a <= i_cfg_data[CHAN_W-1:0];
                CFG_MATCH_DIST: r_dist  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves unless a finished result is waiting.
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] p,
                                                   input logic [CHAN_W-1:0] k);
        return (p > k) ? p - k : k - p;
    endfunction

    function automatic logic [CHAN_W-1:0] sat_diff(input logic [CHAN_W-1:0] p,
                                                   input logic [CHAN_W-1:0] k);
        return (p > k) ? p - k : '0;
    endfunction

    // Stage A: channel differences.
    logic              r_a_valid;
    t_side             r_a_side;
    logic [CHAN_W-1:0] r_a_db, r_a_dg, r_a_dr, r_a_da;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in_valid;
        end
        if (w_en) begin
            r_a_side.pix       <= i_in_data;
            r_a_side.sat_blue  <= sat_diff(i_in_data.pixel_blue, r_key_b);
            r_a_side.sat_green <= sat_diff(i_in_data.pixel_green, r_key_g);
            r_a_side.sat_red   <= sat_diff(i_in_data.pixel_red, r_key_r);
            r_a_side.matched   <= 1'b0;
            r_a_db <= abs_diff(i_in_data.pixel_blue, r_key_b);
            r_a_dg <= abs_diff(i_in_data.pixel_green, r_key_g);
            r_a_dr <= abs_diff(i_in_data.pixel_red, r_key_r);
            r_a_da <= abs_diff(i_in_data.pixel_alpha, r_key_a);
        end
    end

    // Stage B: squares of the differences.
    logic            r_b_valid;
    t_side           r_b_side;
    logic [SQ_W-1:0] r_b_sb, r_b_sg, r_b_sr, r_b_sa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
        if (w_en) begin
            r_b_side <= r_a_side;
            r_b_sb   <= SQ_W'(r_a_db) * SQ_W'(r_a_db);
            r_b_sg   <= SQ_W'(r_a_dg) * SQ_W'(r_a_dg);
            r_b_sr   <= SQ_W'(r_a_dr) * SQ_W'(r_a_dr);
            r_b_sa   <= SQ_W'(r_a_da) * SQ_W'(r_a_da);
        end
    end

    // Stage C: sum of squares and the distance test.
    logic [SUMSQ_W-1:0] w_sumsq;
    logic [SUMSQ_W-1:0] w_dist_sq;
    logic               w_match;
    t_side              w_c_side;
    logic               r_c_valid;
    t_side              r_c_side;
    logic [RAD_W-1:0]   r_c_rad;

    always_comb begin
        w_sumsq   = SUMSQ_W'(r_b_sb) + SUMSQ_W'(r_b_sg) + SUMSQ_W'(r_b_sr) + SUMSQ_W'(r_b_sa);
        w_dist_sq = SUMSQ_W'(r_dist) * SUMSQ_W'(r_dist);
        w_match   = (w_sumsq <= w_dist_sq);
        w_c_side         = r_b_side;
        w_c_side.matched = w_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
        if (w_en) begin
            r_c_side <= w_c_side;
            r_c_rad  <= {w_sumsq, 16'b0};
        end
    end

    // Square root of the sum of squares with eight fraction bits.
    logic              w_sq_valid;
    logic [ROOT_W-1:0] w_sq_root;
    t_side             w_sq_side;

    cdkf_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_valid),
        .i_rad   (r_c_rad),
        .i_side  (r_c_side),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // Stage D: numerator 10*S - 256*D, clamped at zero.
    logic [NUM_W-1:0] w_ten_s;
    logic [NUM_W-1:0] w_neg;
    logic [NUM_W-1:0] w_dvs;
    logic             r_d_valid;
    t_side            r_d_side;
    logic [NUM_W-1:0] r_d_num;

    always_comb begin
        w_ten_s = (NUM_W'(w_sq_root) << 3) + (NUM_W'(w_sq_root) << 1);
        w_neg   = NUM_W'(r_dist) << 8;
        w_dvs   = (NUM_W'(r_dist) << 11) + (NUM_W'(r_dist) << 9);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= w_sq_valid;
        end
        if (w_en) begin
            r_d_side <= w_sq_side;
            if (w_sq_side.matched && (r_dist != '0) && (w_ten_s > w_neg)) begin
                r_d_num <= w_ten_s - w_neg;
            end else begin
                r_d_num <= '0;
            end
        end
    end

    // Fade factor: numerator * 2^F / (2560 * D).
    logic          w_dv_valid;
    logic [QW-1:0] w_fq;
    t_side         w_dv_side;

    cdkf_div_pipe #(
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_valid),
        .i_num   (r_d_num),
        .i_dvs   (w_dvs),
        .i_side  (r_d_side),
        .o_valid (w_dv_valid),
        .o_quot  (w_fq),
        .o_side  (w_dv_side)
    );

    // Stage E: scale the differences and build the result register.
    logic [QW+CHAN_W-1:0] w_pb, w_pg, w_pr, w_pa;
    t_pix_out             n_out;
    logic                 r_out_valid;
    t_pix_out             r_out;

    always_comb begin
        w_pb = (QW+CHAN_W)'(w_dv_side.sat_blue) * (QW+CHAN_W)'(w_fq);
        w_pg = (QW+CHAN_W)'(w_dv_side.sat_green) * (QW+CHAN_W)'(w_fq);
        w_pr = (QW+CHAN_W)'(w_dv_side.sat_red) * (QW+CHAN_W)'(w_fq);
        w_pa = {w_fq, {CHAN_W{1'b0}}} - (QW+CHAN_W)'(w_fq);
        if (w_dv_side.matched) begin
            n_out.result_blue  = w_pb[QW+CHAN_W-1:QW];
            n_out.result_green = w_pg[QW+CHAN_W-1:QW];
            n_out.result_red   = w_pr[QW+CHAN_W-1:QW];
            n_out.result_alpha = w_pa[QW+CHAN_W-1:QW];
            n_out.matched      = 1'b1;
        end else begin
            n_out.result_blue  = w_dv_side.pix.pixel_blue;
            n_out.result_green = w_dv_side.pix.pixel_green;
            n_out.result_red   = w_dv_side.pix.pixel_red;
            n_out.result_alpha = w_dv_side.pix.pixel_alpha;
            n_out.matched      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv_valid;
        end
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/cdkf_checker.sv @@
// Port-level checks for the color distance key fade block, with its bind.
module cdkf_checker
    import cdkf_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_pix_out o_out_data
);

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transfer changed while stalled");

    // Nothing leaves the block in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // With no result waiting, the block takes input.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

    // A faded pixel keeps its alpha below 0.9 of full scale.
    a_fade_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.matched |-> o_out_data.result_alpha <= 8'd229)
        else $error("faded alpha out of range");

endmodule

bind color_distance_key_fade cdkf_checker u_cdkf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ test/cdkf_checker.sv @@
// Checker for the color distance key fade block: watches the channels, predicts and compares.
module cdkf_tb_checker
    import cdkf_pkg::*;
#(
    parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_pix_in              i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_pix_out             i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // Local copy of the key color and match distance.
    logic [CHAN_W-1:0] key_b, key_g, key_r, key_a;
    logic [DIST_W-1:0] match_dist;

    t_pix_out keyed_q[$];

    assign o_pending = keyed_q.size();

    // Integer square root, floored.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned abs_sq(input int p, input int k);
        longint unsigned d;
        d = (p > k) ? longint'(p - k) : longint'(k - p);
        return d * d;
    endfunction

    function automatic longint unsigned fade_chan(input int p, input int k,
                                                  input longint unsigned fq);
        longint unsigned d;
        d = (p > k) ? longint'(p - k) : 64'd0;
        return (d * fq) >> FACTOR_FRAC_BITS;
    endfunction

    // Computes the keyed pixel for one input pixel.
    function automatic t_pix_out key_pixel(input t_pix_in px);
        t_pix_out        res;
        longint unsigned sumsq, dist_v, one, root8, pos, neg, fq;
        dist_v = match_dist;
        sumsq  = abs_sq(px.pixel_blue, key_b) + abs_sq(px.pixel_green, key_g)
               + abs_sq(px.pixel_red, key_r) + abs_sq(px.pixel_alpha, key_a);
        if (sumsq > dist_v * dist_v) begin
            res.result_blue  = px.pixel_blue;
            res.result_green = px.pixel_green;
            res.result_red   = px.pixel_red;
            res.result_alpha = px.pixel_alpha;
            res.matched      = 1'b0;
            return res;
        end
        one   = 64'd1 << FACTOR_FRAC_BITS;
        root8 = floor_sqrt(sumsq << 16);
        pos   = 10 * root8 * one;
        neg   = 256 * dist_v * one;
        fq    = 0;
        if (dist_v != 0 && pos > neg) fq = (pos - neg) / (2560 * dist_v);
        res.result_blue  = CHAN_W'(fade_chan(px.pixel_blue, key_b, fq));
        res.result_green = CHAN_W'(fade_chan(px.pixel_green, key_g, fq));
        res.result_red   = CHAN_W'(fade_chan(px.pixel_red, key_r, fq));
        res.result_alpha = CHAN_W'((255 * fq) >> FACTOR_FRAC_BITS);
        res.matched      = 1'b1;
        return res;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    // Track config, queue predictions and compare results at each edge.
    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            key_b <= '0; key_g <= '0; key_r <= '0; key_a <= '0;
            match_dist <= 9'd1;
            o_fail_count = 0;
            keyed_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) keyed_q.push_back(key_pixel(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (keyed_q.size() == 0) begin
                    report("unexpected transfer", 1, 0);
                end else begin
                    want = keyed_q.pop_front();
                    if (i_out_data.result_blue != want.result_blue)
                        report("blue", i_out_data.result_blue, want.result_blue);
                    if (i_out_data.result_green != want.result_green)
                        report("green", i_out_data.result_green, want.result_green);
                    if (i_out_data.result_red != want.result_red)
                        report("red", i_out_data.result_red, want.result_red);
                    if (i_out_data.result_alpha != want.result_alpha)
                        report("alpha", i_out_data.result_alpha, want.result_alpha);
                    if (i_out_data.matched != want.matched)
                        report("matched", i_out_data.matched, want.matched);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_BLUE:   key_b <= i_cfg_data[CHAN_W-1:0];
                    CFG_KEY_GREEN:  key_g <= i_cfg_data[CHAN_W-1:0];
                    CFG_KEY_RED:    key_r <= i_cfg_data[CHAN_W-1:0];
                    CFG_KEY_ALPHA:  key_a <= i_cfg_data[CHAN_W-1:0];
                    CFG_MATCH_DIST: match_dist <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ test/testbench.sv @@
// Stimulus and verdict for the color distance key fade block.
module testbench;
    import cdkf_pkg::*;

    localparam int LATENCY    = 4 + 17 + FACTOR_FRAC_BITS_DEF + 1;
    localparam int CYCLE_CAP  = 400000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_pix_in              in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_pix_out             out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    bit                   hold_off = 1'b0;
    logic [CHAN_W-1:0]    key_cur[4];
    logic [DIST_W-1:0]    dist_cur;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    color_distance_key_fade dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    cdkf_tb_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(posedge clk) begin
        if (hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input t_cfg_idx idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_key(input int b, input int g, input int r, input int a,
                           input int d);
        write_reg(CFG_KEY_BLUE, b);
        write_reg(CFG_KEY_GREEN, g);
        write_reg(CFG_KEY_RED, r);
        write_reg(CFG_KEY_ALPHA, a);
        write_reg(CFG_MATCH_DIST, d);
        key_cur[0] = CHAN_W'(b);
        key_cur[1] = CHAN_W'(g);
        key_cur[2] = CHAN_W'(r);
        key_cur[3] = CHAN_W'(a);
        dist_cur = DIST_W'(d);
    endtask

    // Offers one pixel and waits for its transfer; valid stays high between pixels unless an idle gap is drawn.
    task automatic send_pixel(input t_pix_in px);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Waits until every result is back, plus the pipeline depth.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // A pixel near the current key, so that many of them match.
    function automatic t_pix_in near_key(input int spread);
        t_pix_in px;
        int      v[4];
        for (int c = 0; c < 4; c++) begin
            v[c] = int'(key_cur[c]) + $urandom_range(2 * spread) - spread;
            if (v[c] < 0) v[c] = 0;
            if (v[c] > 255) v[c] = 255;
        end
        px = {v[0][7:0], v[1][7:0], v[2][7:0], v[3][7:0]};
        return px;
    endfunction

    task automatic random_phase(input int count);
        t_pix_in px;
        int      spread;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0) begin
                px = $urandom;
            end else begin
                spread = dist_cur / 2 + 1;
                px = near_key(spread);
            end
            send_pixel(px);
        end
    endtask

    initial begin
        key_cur = '{default: 0};
        dist_cur = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset key, extremes, equal-to-key and saturation cases.
        send_pixel('0);
        send_pixel('1);
        send_pixel(32'h01000000);
        drain();
        set_key(100, 150, 200, 50, 510);
        send_pixel({8'd100, 8'd150, 8'd200, 8'd50});
        send_pixel({8'd110, 8'd150, 8'd200, 8'd50});
        send_pixel({8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel({8'd90, 8'd255, 8'd10, 8'd50});
        send_pixel({8'd255, 8'd0, 8'd255, 8'd0});
        drain();
        set_key(255, 255, 255, 255, 1);
        send_pixel('1);
        send_pixel({8'd254, 8'd255, 8'd255, 8'd255});
        send_pixel({8'd254, 8'd254, 8'd255, 8'd255});
        drain();
        set_key(0, 0, 0, 0, 510);
        send_pixel('1);
        send_pixel({8'd255, 8'd255, 8'd0, 8'd0});
        send_pixel({8'd40, 8'd0, 8'd0, 8'd0});
        send_pixel({8'd51, 8'd0, 8'd0, 8'd0});
        drain();

        // Random phases over several key settings and idle patterns.
        send_idle_pct = 15; recv_idle_pct = 66;
        set_key(128, 64, 192, 255, 200);
        random_phase(300);
        drain();
        send_idle_pct = 66; recv_idle_pct = 15;
        set_key($urandom_range(255), $urandom_range(255), $urandom_range(255),
                $urandom_range(255), $urandom_range(510, 1));
        random_phase(300);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        set_key($urandom_range(255), $urandom_range(255), $urandom_range(255),
                $urandom_range(255), $urandom_range(40, 1));
        random_phase(300);

        // Long receiver hold-off while pixels keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (LATENCY * 3) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(150);
        join
        drain();
        set_key(0, 255, 0, 255, 510);
        random_phase(250);
        drain();
        recv_idle_pct = 30; send_idle_pct = 30;
        set_key($urandom_range(255), $urandom_range(255), $urandom_range(255),
                $urandom_range(255), $urandom_range(510, 1));
        random_phase(380);
        drain();

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
